[sv/h3d_pkg.sv]
`timescale 1ns / 1ps

package h3d_pkg;

    localparam int BYTE_BITS        = 8;
    localparam int VALUE_W          = 62;
    localparam int VARINT_LEFT_W    = 3;
    localparam int VARINT_HEAD_BITS = 6;

    localparam logic [VALUE_W-1:0] TYPE_DATA    = VALUE_W'(0);
    localparam logic [VALUE_W-1:0] TYPE_HEADERS = VALUE_W'(1);

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_HEADERS = 2'd2,
        KIND_SKIP    = 2'd3
    } t_byte_kind;

    typedef struct packed {
        logic [BYTE_BITS-1:0] payload_byte;
        t_byte_kind           byte_kind;
        logic [VALUE_W-1:0]   frame_kind_code;
        logic                 frame_end;
        logic                 stream_end;
        logic                 status;
    } t_result;

endpackage

[sv/h3d_stream_if.sv]
`timescale 1ns / 1ps

interface h3d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       buffer_last;

    modport source (output valid, output stream_byte, output buffer_last, input ready);
    modport sink   (input valid, input stream_byte, input buffer_last, output ready);
endinterface

interface h3d_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [1:0]  byte_kind;
    logic [61:0] frame_kind_code;
    logic        frame_end;
    logic        stream_end;
    logic        status;

    modport source (output valid, output payload_byte, output byte_kind,
                    output frame_kind_code, output frame_end, output stream_end,
                    output status, input ready);
    modport sink   (input valid, input payload_byte, input byte_kind,
                    input frame_kind_code, input frame_end, input stream_end,
                    input status, output ready);
endinterface

[sv/h3d_parser.sv]
`timescale 1ns / 1ps

module h3d_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [h3d_pkg::BYTE_BITS-1:0] i_byte,
    input  logic                         i_last,
    output h3d_pkg::t_result             o_res
);
    import h3d_pkg::*;

    t_phase                   r_phase,   n_phase;
    logic [VARINT_LEFT_W-1:0] r_left,    n_left;
    logic [VALUE_W-1:0]       r_acc,     n_acc;
    logic [VALUE_W-1:0]       r_type,    n_type;
    logic [VALUE_W-1:0]       r_pay,     n_pay;

    logic [VARINT_LEFT_W-1:0] w_feed_left;
    logic [VALUE_W-1:0]       w_feed_acc;
    logic                     w_feed_done;
    logic [VALUE_W-1:0]       w_pay_dec;

    // varint assembler: first byte sets size and top bits, later bytes shift in
    always_comb begin
        if (r_left == '0) begin
            w_feed_acc = VALUE_W'(i_byte[VARINT_HEAD_BITS-1:0]);
            unique case (i_byte[BYTE_BITS-1:VARINT_HEAD_BITS])
                2'd0:    w_feed_left = VARINT_LEFT_W'(0);
                2'd1:    w_feed_left = VARINT_LEFT_W'(1);
                2'd2:    w_feed_left = VARINT_LEFT_W'(3);
                default: w_feed_left = VARINT_LEFT_W'(7);
            endcase
        end else begin
            w_feed_acc  = {r_acc[VALUE_W-BYTE_BITS-1:0], i_byte};
            w_feed_left = r_left - VARINT_LEFT_W'(1);
        end
        w_feed_done = (w_feed_left == '0);
        w_pay_dec   = r_pay - VALUE_W'(1);
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_acc   = r_acc;
        n_type  = r_type;
        n_pay   = r_pay;

        o_res                 = '0;
        o_res.payload_byte    = i_byte;
        o_res.byte_kind       = KIND_HEADER;
        o_res.stream_end      = i_last;

        unique case (r_phase)
            PH_PAYLOAD: begin
                o_res.frame_kind_code = r_type;
                if (r_type == TYPE_DATA) begin
                    o_res.byte_kind = KIND_DATA;
                end else if (r_type == TYPE_HEADERS) begin
                    o_res.byte_kind = KIND_HEADERS;
                end else begin
                    o_res.byte_kind = KIND_SKIP;
                end
                n_pay = w_pay_dec;
                if (w_pay_dec == '0) begin
                    o_res.frame_end = 1'b1;
                    n_phase         = PH_TYPE;
                end
            end
            PH_LEN: begin
                n_acc  = w_feed_acc;
                n_left = w_feed_left;
                if (w_feed_done) begin
                    n_pay = w_feed_acc;
                    if (w_feed_acc == '0) begin
                        o_res.frame_end = 1'b1;
                        n_phase         = PH_TYPE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                n_acc  = w_feed_acc;
                n_left = w_feed_left;
                if (w_feed_done) begin
                    n_type  = w_feed_acc;
                    n_phase = PH_LEN;
                end
            end
        endcase

        // buffer ends inside a frame: flag it and start clean
        if (i_last && (n_phase != PH_TYPE || n_left != '0)) begin
            o_res.status = 1'b1;
            n_phase      = PH_TYPE;
            n_left       = '0;
            n_acc        = '0;
            n_type       = '0;
            n_pay        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_left  <= '0;
            r_acc   <= '0;
            r_type  <= '0;
            r_pay   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_type  <= n_type;
            r_pay   <= n_pay;
        end
    end

endmodule

[sv/http3_frame_deframer.sv]
`timescale 1ns / 1ps

// HTTP/3 frame deframer. Feed the stream one byte per transfer on i_in and
// take exactly one result per byte on o_out, in order. Each frame is a QUIC
// varint type, a varint length, then the payload; header bytes come out with
// byte_kind 0 and code 0, payload bytes tagged DATA, HEADERS or skipped, with
// the decoded type in frame_kind_code. frame_end marks the byte that closes a
// frame (the last length byte for an empty frame). On the byte flagged
// buffer_last, stream_end is set, and status is 1 if the buffer stopped inside
// a header or payload; the parser then drops the partial frame, so the next
// buffer starts fresh. Throughput is one byte per clock, sustained while o_out
// accepts results: the parser state (a 62-bit length down-counter and compare,
// an 8-bit varint shift) updates in the cycle of the transfer. Each result is
// registered in the output register, or in the skid while o_out stalls. A
// two-deep output (result register plus skid) keeps i_in ready while one
// result waits; ready drops only once both are full.
module http3_frame_deframer (
    input  logic   i_clk,
    input  logic   i_rst_n,
    h3d_in_if.sink    i_in,
    h3d_out_if.source o_out
);
    import h3d_pkg::*;

    t_result w_res;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept;
    logic    w_out_free;

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && i_in.ready;
    // output slot can take new data this edge: empty, or its result moves on
    assign w_out_free = !r_out_valid || o_out.ready;

    h3d_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_accept),
        .i_byte  (i_in.stream_byte),
        .i_last  (i_in.buffer_last),
        .o_res   (w_res)
    );

    // valid flags of the output register and its skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= w_accept;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload: advance skid into the output, park new results in the skid
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (w_accept) begin
                    r_skid <= w_res;
                end
            end else if (w_accept) begin
                r_out <= w_res;
            end
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.payload_byte    = r_out.payload_byte;
    assign o_out.byte_kind       = r_out.byte_kind;
    assign o_out.frame_kind_code = r_out.frame_kind_code;
    assign o_out.frame_end       = r_out.frame_end;
    assign o_out.stream_end      = r_out.stream_end;
    assign o_out.status          = r_out.status;

endmodule

[sv/h3d_checker.sv]
`timescale 1ns / 1ps

module h3d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [7:0]  i_payload_byte,
    input logic [1:0]  i_byte_kind,
    input logic [61:0] i_frame_kind_code,
    input logic        i_frame_end,
    input logic        i_stream_end,
    input logic        i_status
);
    import h3d_pkg::*;

    // truncation is only reported on the buffer's last byte
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_stream_end |-> !i_status)
        else $error("status set on a byte that is not the buffer end");

    // a byte that closes a frame leaves the parser between frames
    a_end_not_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_end |-> !i_status)
        else $error("frame end reported together with truncation");

    // header bytes carry no frame type
    a_header_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_byte_kind == KIND_HEADER |-> i_frame_kind_code == '0)
        else $error("header byte with nonzero frame type");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_payload_byte) && $stable(i_byte_kind)
            && $stable(i_frame_kind_code) && $stable(i_frame_end))
        else $error("result changed while stalled");

endmodule

bind http3_frame_deframer h3d_checker u_h3d_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_out.valid),
    .i_ready           (o_out.ready),
    .i_payload_byte    (o_out.payload_byte),
    .i_byte_kind       (o_out.byte_kind),
    .i_frame_kind_code (o_out.frame_kind_code),
    .i_frame_end       (o_out.frame_end),
    .i_stream_end      (o_out.stream_end),
    .i_status          (o_out.status)
);

[tb/tb_http3_frame_deframer.sv]
`timescale 1ns / 1ps

module tb_http3_frame_deframer;
    import h3d_pkg::*;

    localparam int N_DIR          = 24;
    localparam int RAND_PER_PHASE = 270;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SHOW_MAX       = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       fixed;
        t_result    want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    h3d_in_if  in_ch ();
    h3d_out_if out_ch ();

    http3_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow parser state
    t_phase             p_phase;
    logic [2:0]         p_vleft;
    logic [VALUE_W-1:0] p_acc;
    logic [VALUE_W-1:0] p_type;
    logic [VALUE_W-1:0] p_left;

    t_result    want_results [$];
    logic [7:0] pkt_bytes [$];
    t_dir_row   dir_rows [N_DIR];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void deframe_clear();
        p_phase = PH_TYPE;
        p_vleft = '0;
        p_acc   = '0;
        p_type  = '0;
        p_left  = '0;
    endfunction

    // Shift one byte into the varint being assembled; 1 when it is complete.
    function automatic bit varint_take(input logic [7:0] b);
        if (p_vleft == 0) begin
            p_acc   = VALUE_W'(b[VARINT_HEAD_BITS-1:0]);
            p_vleft = 3'((4'd1 << b[7:6]) - 4'd1);
        end else begin
            p_acc   = {p_acc[VALUE_W-BYTE_BITS-1:0], b};
            p_vleft = p_vleft - 3'd1;
        end
        return p_vleft == 0;
    endfunction

    function automatic t_result deframe_step(input logic [7:0] b, input logic last);
        t_result r;
        r              = '0;
        r.payload_byte = b;
        r.byte_kind    = KIND_HEADER;
        r.stream_end   = last;
        case (p_phase)
            PH_PAYLOAD: begin
                r.frame_kind_code = p_type;
                r.byte_kind = (p_type == TYPE_DATA)    ? KIND_DATA :
                              (p_type == TYPE_HEADERS) ? KIND_HEADERS : KIND_SKIP;
                p_left = p_left - 1'b1;
                if (p_left == 0) begin
                    r.frame_end = 1'b1;
                    p_phase     = PH_TYPE;
                end
            end
            PH_LEN: begin
                if (varint_take(b)) begin
                    p_left = p_acc;
                    if (p_left == 0) begin
                        r.frame_end = 1'b1;
                        p_phase     = PH_TYPE;
                    end else begin
                        p_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                if (varint_take(b)) begin
                    p_type  = p_acc;
                    p_phase = PH_LEN;
                end
            end
        endcase
        // Buffer ran out mid-frame: flag it and drop the partial frame.
        if (last && (p_phase != PH_TYPE || p_vleft != 0)) begin
            r.status = 1'b1;
            deframe_clear();
        end
        return r;
    endfunction

    // Append v as a varint, in its shortest size or, half the time, a random size from the shortest up to eight bytes.
    function automatic void put_varint(input logic [VALUE_W-1:0] v);
        int          need;
        int          s;
        int          n;
        logic [63:0] w;
        need = (v < 62'd64) ? 0 : (v < 62'd16384) ? 1 : (v < 62'h4000_0000) ? 2 : 3;
        s    = $urandom_range(1) ? need : $urandom_range(3, need);
        n    = 1 << s;
        w    = (64'(s) << (8 * n - 2)) | {2'b00, v};
        for (int i = n - 1; i >= 0; i--)
            pkt_bytes.push_back(8'(w >> (8 * i)));
    endfunction

    // One buffer: mostly well-formed frames, some cut short, some pure noise.
    function automatic void build_buffer();
        int                 nframes;
        int                 pick;
        int                 cut;
        logic [63:0]        r64;
        logic [VALUE_W-1:0] kind_code;
        logic [VALUE_W-1:0] len;
        bit                 open_ended;
        pkt_bytes.delete();
        open_ended = 1'b0;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(12, 1)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        nframes = $urandom_range(4, 1);
        for (int f = 0; f < nframes && !open_ended; f++) begin
            pick = $urandom_range(99);
            r64  = {$urandom, $urandom};
            if (pick < 40)
                kind_code = TYPE_DATA;
            else if (pick < 70)
                kind_code = TYPE_HEADERS;
            else if (pick < 85)
                kind_code = VALUE_W'($urandom_range(63, 2));
            else
                kind_code = r64[VALUE_W-1:0];
            put_varint(kind_code);
            pick = $urandom_range(99);
            if (pick < 15) begin
                len = '0;
            end else if (pick < 90) begin
                len = VALUE_W'($urandom_range(8, 1));
            end else if (pick < 97) begin
                len = VALUE_W'($urandom_range(64, 9));
            end else begin
                // Huge length: the buffer always ends inside this payload.
                r64        = {$urandom, $urandom};
                len        = r64[VALUE_W-1:0] | VALUE_W'(128);
                open_ended = 1'b1;
            end
            put_varint(len);
            if (open_ended) begin
                repeat ($urandom_range(6, 0)) pkt_bytes.push_back(8'($urandom));
            end else begin
                repeat (int'(len)) pkt_bytes.push_back(8'($urandom));
            end
        end
        if (!open_ended && pkt_bytes.size() > 1 && $urandom_range(99) < 20) begin
            cut = $urandom_range(pkt_bytes.size() - 1, 1);
            while (pkt_bytes.size() > cut) pkt_bytes.delete(pkt_bytes.size() - 1);
        end
    endfunction

    // Hold the byte until it transfers, then log its expected result.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic fixed, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        in_ch.buffer_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = deframe_step(b, last);
        want_results.push_back(fixed ? want : predicted);
    endtask

    // Output side: random back-pressure, result check, stall watchdog count.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                got.payload_byte    = out_ch.payload_byte;
                got.byte_kind       = t_byte_kind'(out_ch.byte_kind);
                got.frame_kind_code = out_ch.frame_kind_code;
                got.frame_end       = out_ch.frame_end;
                got.stream_end      = out_ch.stream_end;
                got.status          = out_ch.status;
                if (want_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= SHOW_MAX)
                        $display("unexpected result: byte=%h kind=%0d code=%h end=%b last=%b st=%b",
                                 got.payload_byte, got.byte_kind, got.frame_kind_code,
                                 got.frame_end, got.stream_end, got.status);
                end else begin
                    exp_r = want_results.pop_front();
                    if (got.payload_byte    !== exp_r.payload_byte    ||
                        got.byte_kind       !== exp_r.byte_kind       ||
                        got.frame_kind_code !== exp_r.frame_kind_code ||
                        got.frame_end       !== exp_r.frame_end       ||
                        got.stream_end      !== exp_r.stream_end      ||
                        got.status          !== exp_r.status) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= SHOW_MAX) begin
                            $display("mismatch exp: byte=%h kind=%0d code=%h end=%b last=%b st=%b",
                                     exp_r.payload_byte, exp_r.byte_kind, exp_r.frame_kind_code,
                                     exp_r.frame_end, exp_r.stream_end, exp_r.status);
                            $display("         got: byte=%h kind=%0d code=%h end=%b last=%b st=%b",
                                     got.payload_byte, got.byte_kind, got.frame_kind_code,
                                     got.frame_end, got.stream_end, got.status);
                        end
                    end
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        int sent;
        deframe_clear();
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.stream_byte = '0;
        in_ch.buffer_last = 1'b0;
        out_ch.ready      = 1'b0;

        // Directed rows: b, last, fixed, typed-in result (fixed rows only).
        dir_rows = '{
            // empty DATA frame
            '{8'h00, 1'b0, 1'b1, '{8'h00, KIND_HEADER, 62'd0, 1'b0, 1'b0, 1'b0}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, KIND_HEADER, 62'd0, 1'b1, 1'b0, 1'b0}},
            // HEADERS frame, two payload bytes
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hAA, 1'b0, 1'b0, '0},
            // unknown type in a two-byte varint, skipped payload
            '{8'h40, 1'b0, 1'b0, '0},
            '{8'h21, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h55, 1'b0, 1'b0, '0},
            // largest type in an eight-byte varint, buffer ends on frame end
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0},
            // one-byte buffer cut inside a type varint
            '{8'hC0, 1'b1, 1'b1, '{8'hC0, KIND_HEADER, 62'd0, 1'b0, 1'b1, 1'b1}},
            // DATA payload cut short
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h05, 1'b0, 1'b0, '0},
            '{8'h12, 1'b1, 1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct = 8;
        recv_gap_pct = 59;
        for (int i = 0; i < N_DIR; i++)
            send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);

        // Three traffic phases: slow sink, slow source, then full rate.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct = 8;
                    recv_gap_pct = 59;
                end
                1: begin
                    send_gap_pct = 59;
                    recv_gap_pct = 8;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                build_buffer();
                foreach (pkt_bytes[i])
                    send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, '0);
                sent = sent + pkt_bytes.size();
            end
        end
        in_ch.valid <= 1'b0;

        while (want_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && want_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
